// File: design/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned LenW    = 61;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  // controller to datapath
  typedef struct packed {
    logic        push;
    byte_sel_t   sel;
    logic [2:0]  len_idx;
    logic        load;
    logic        round;
    logic [5:0]  rnd_idx;
    logic        update;
    logic [2:0]  out_idx;
    logic        clear;
  } sha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
  } sha_stat_t;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam logic [WordW-1:0] INIT_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] ROUND_K [0:Rounds-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// File: design/sha256_dp.sv
module sha256_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::sha_cmd_t  cmd,
  input  logic [7:0]            in_byte,
  output sha256_pkg::sha_stat_t stat,
  output logic [31:0]           word_out
);
  import sha256_pkg::*;

  logic [WordW-1:0] h_r [0:7];
  logic [WordW-1:0] v_r [0:7];
  logic [WordW-1:0] w_r [0:15];
  logic [5:0]       fill_r;
  logic [LenW-1:0]  len_r;

  logic [63:0]      len_bits;
  logic [7:0]       push_byte;
  logic [WordW-1:0] w_new, t1, t2;
  logic [WordW-1:0] a, e;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  assign len_bits = {len_r, 3'b000};

  always_comb begin
    case (cmd.sel)
      BSEL_IN:   push_byte = in_byte;
      BSEL_PAD:  push_byte = PadByte;
      BSEL_ZERO: push_byte = 8'h00;
      BSEL_LEN:  push_byte = len_bits[{~cmd.len_idx, 3'b000} +: 8];
      default:   push_byte = 8'h00;
    endcase
  end

  // next schedule word from the sliding window
  always_comb begin
    w_new = w_r[0]
          + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3))
          + w_r[9]
          + (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10));
  end

  always_comb begin
    a  = v_r[0];
    e  = v_r[4];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + ROUND_K[cmd.rnd_idx] + w_r[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      if (cmd.push) begin
        fill_r <= fill_r + 6'd1;
        if (cmd.sel == BSEL_IN) len_r <= len_r + {{(LenW-1){1'b0}}, 1'b1};
      end
      if (cmd.update) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.clear) begin
        len_r <= '0;
        for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    // bytes enter big-endian at the bottom of the 512-bit window
    if (cmd.push) begin
      for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      w_r[15] <= {w_r[15][23:0], push_byte};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign stat.fill = fill_r;
  assign word_out  = h_r[cmd.out_idx];

endmodule

// File: design/sha256_ctrl.sv
module sha256_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tlast,
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tlast,
  input  sha256_pkg::sha_stat_t stat,
  output sha256_pkg::sha_cmd_t  cmd
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_ZERO,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_UPD,
    ST_OUT
  } state_t;

  state_t     state_r, ret_r;
  logic [5:0] rnd_r;
  logic [2:0] idx_r;
  logic       in_acc, out_acc, block_full;

  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign block_full = (stat.fill == 6'd63);
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = (state_r == ST_OUT) && (idx_r == 3'd7);

  always_comb begin
    cmd         = '0;
    cmd.sel     = BSEL_IN;
    cmd.len_idx = idx_r;
    cmd.rnd_idx = rnd_r;
    cmd.out_idx = idx_r;
    unique case (state_r)
      ST_IDLE:  cmd.push = in_acc && !in_tuser;
      ST_PAD80: begin
        cmd.push = 1'b1;
        cmd.sel  = BSEL_PAD;
      end
      ST_ZERO:  begin
        cmd.push = (stat.fill != LenStart);
        cmd.sel  = BSEL_ZERO;
      end
      ST_LEN:   begin
        cmd.push = 1'b1;
        cmd.sel  = BSEL_LEN;
      end
      ST_LOAD:  cmd.load = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_UPD:   cmd.update = 1'b1;
      ST_OUT:   cmd.clear = out_acc && (idx_r == 3'd7);
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser) begin
              state_r <= ST_PAD80;
            end else if (block_full) begin
              state_r <= ST_LOAD;
              ret_r   <= in_tlast ? ST_PAD80 : ST_IDLE;
            end else if (in_tlast) begin
              state_r <= ST_PAD80;
            end
          end
        end
        ST_PAD80: begin
          if (block_full) begin
            state_r <= ST_LOAD;
            ret_r   <= ST_ZERO;
          end else begin
            state_r <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (stat.fill == LenStart) begin
            state_r <= ST_LEN;
            idx_r   <= '0;
          end else if (block_full) begin
            state_r <= ST_LOAD;
            ret_r   <= ST_ZERO;
          end
        end
        ST_LEN: begin
          idx_r <= idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_r <= ST_LOAD;
            ret_r   <= ST_OUT;
          end
        end
        ST_LOAD: begin
          rnd_r   <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= ST_UPD;
        end
        ST_UPD: begin
          state_r <= ret_r;
          idx_r   <= '0;
        end
        ST_OUT: begin
          if (out_acc) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/sha256_digest_unit.sv
// message bytes are accepted only in the idle state; every 64th byte starts a
// compression (load, 64 rounds on a single round unit, chain update)
// a final item then pushes the padding byte, the zero bytes and the length
// bytes, with a compression per padded block, before the eight digest words
// go out one a cycle while out_tready is high
// synchronous active-low reset restores the initial hash and clears the
// byte count; the same happens after the eighth digest word is taken
module sha256_digest_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // is_final
  input  logic        in_tuser,   // empty_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic        out_tlast   // is_last_word
);
  import sha256_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha256_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_byte  (in_tdata),
    .stat     (stat),
    .word_out (out_tdata)
  );

endmodule
